// ===== src/temp_scratchpad_decoder_macros.svh =====
// Assertion macros shared by the decoder RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef TEMP_SCRATCHPAD_DECODER_MACROS_SVH
`define TEMP_SCRATCHPAD_DECODER_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in the same cycle.
`define TDEC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define TDEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tdec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdec_pkg;

	// Highest device number plus one that produces results.
	localparam int MAX_DEVICES = 64;
	localparam int DEV_CMP_W   = 9;

	localparam logic [7:0] CRC_POLY       = 8'h8C;
	localparam logic [7:0] CRC_SEED       = 8'h00;

	// Scratchpad byte positions.
	localparam logic [3:0] IDX_TEMP_LSB   = 4'd0;
	localparam logic [3:0] IDX_TEMP_MSB   = 4'd1;
	localparam logic [3:0] IDX_CONFIG     = 4'd4;
	localparam logic [3:0] IDX_COUNT_REM  = 4'd6;
	localparam logic [3:0] IDX_COUNT_PER  = 4'd7;
	localparam logic [3:0] IDX_CRC        = 4'd8;

	localparam logic [7:0]  FAMILY_OLD     = 8'h10;
	localparam logic [7:0]  COUNT_PER_C    = 8'h10;
	localparam logic [15:0] OLD_FRAC_MASK  = 16'hFFF0;
	localparam logic [15:0] OLD_FRAC_BIAS  = 16'd12;
	localparam logic [7:0]  RES_MASK       = 8'h60;
	localparam logic [7:0]  RES_9BIT       = 8'h00;
	localparam logic [7:0]  RES_10BIT      = 8'h20;
	localparam logic [7:0]  RES_11BIT      = 8'h40;
	localparam logic [15:0] MASK_9BIT      = 16'hFFF8;
	localparam logic [15:0] MASK_10BIT     = 16'hFFFC;
	localparam logic [15:0] MASK_11BIT     = 16'hFFFE;

	localparam logic [3:0] FAIL_LIMIT_RESET = 4'd10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [3:0] byte_index;
		logic [7:0] family_code;
		logic [5:0] device_index;
	} byte_item_t;

	typedef struct packed {
		logic [15:0] temperature_raw;
		logic        crc_ok;
		logic        rescan_request;
		logic [5:0]  result_device;
	} result_item_t;

	// Scratchpad bytes that the temperature decode needs.
	typedef struct packed {
		logic [7:0] temp_lsb;
		logic [7:0] temp_msb;
		logic [7:0] config_reg;
		logic [7:0] count_remain;
		logic [7:0] count_per_c;
	} kept_bytes_t;

endpackage

`default_nettype wire

// ===== src/temp_scratchpad_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// byte      in         byte_valid / byte_ready     byte_item   (byte_item_t)
// result    out        result_valid / result_ready result_item (result_item_t)
// config    in         cfg_we (no wait)            cfg_wdata   (crc_fail_limit)
//
// Each byte is registered in the stage register, and a CRC byte then in the result register;
// a new byte transfer can be taken in every cycle unless a CRC byte waits for the result register.
// Throughput is set by the single processing stage, whose CRC and decode are combinational.
// A held result stalls a CRC byte that wants the result register, and the byte input with it; other bytes pass.
// Reset clears the CRC, the kept bytes and the failure count, and sets the limit to 10.

`include "temp_scratchpad_decoder_macros.svh"

module temp_scratchpad_decoder import tdec_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         byte_valid,
	output logic              byte_ready,
	input  wire byte_item_t   byte_item,
	output logic              result_valid,
	input  wire logic         result_ready,
	output result_item_t      result_item,
	input  wire logic         cfg_we,
	input  wire logic [3:0]   cfg_wdata
);

	// Stage register holding the byte under work.
	logic         valid_s1;
	byte_item_t   item_s1;

	// Block state.
	logic [7:0]   running_crc_q;
	kept_bytes_t  kept_q;
	logic [3:0]   fail_count_q;
	logic [3:0]   fail_limit_q;

	// Result register.
	logic         result_valid_q;
	result_item_t result_item_q;

	logic         is_data_byte;
	logic         is_crc_byte;
	logic         dev_in_range;
	logic         emit;
	logic         slot_free;
	logic         advance;
	logic [7:0]   crc_seed;
	logic [7:0]   crc_next;
	logic         crc_match;
	logic [4:0]   fail_inc;
	logic         over_limit;
	logic [15:0]  decoded_temp;

	// Bytes 0 to 7 feed the CRC; byte 8 carries the sensor's CRC; the rest are dropped.
	assign is_data_byte = item_s1.byte_index < IDX_CRC;
	assign is_crc_byte  = item_s1.byte_index == IDX_CRC;
	assign dev_in_range = {{(DEV_CMP_W - 6){1'b0}}, item_s1.device_index}
		< DEV_CMP_W'(MAX_DEVICES);
	assign emit         = valid_s1 && is_crc_byte && dev_in_range;

	// The stage moves on unless it has a result and the result register is still occupied.
	assign slot_free  = !result_valid_q || result_ready;
	assign advance    = valid_s1 && (!emit || slot_free);
	assign byte_ready = !valid_s1 || advance;

	// Byte 0 restarts the CRC from zero.
	assign crc_seed = (item_s1.byte_index == IDX_TEMP_LSB) ? CRC_SEED : running_crc_q;

	tdec_crc8 u_crc8 (
		.crc_in  (crc_seed),
		.data    (item_s1.data_byte),
		.crc_out (crc_next)
	);

	tdec_temp u_temp (
		.kept            (kept_q),
		.family_code     (item_s1.family_code),
		.temperature_raw (decoded_temp)
	);

	assign crc_match  = running_crc_q == item_s1.data_byte;
	assign fail_inc   = {1'b0, fail_count_q} + 5'd1;
	assign over_limit = fail_inc > {1'b0, fail_limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_limit_q <= FAIL_LIMIT_RESET;
		end else if (cfg_we) begin
			fail_limit_q <= cfg_wdata;
		end
	end

	// CRC and kept bytes follow every data byte as its index says.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
			kept_q        <= '0;
		end else if (advance && is_data_byte) begin
			running_crc_q <= crc_next;
			case (item_s1.byte_index)
				IDX_TEMP_LSB:  kept_q.temp_lsb     <= item_s1.data_byte;
				IDX_TEMP_MSB:  kept_q.temp_msb     <= item_s1.data_byte;
				IDX_CONFIG:    kept_q.config_reg   <= item_s1.data_byte;
				IDX_COUNT_REM: kept_q.count_remain <= item_s1.data_byte;
				IDX_COUNT_PER: kept_q.count_per_c  <= item_s1.data_byte;
				default: begin
				end
			endcase
		end
	end

	// A match clears the failure count; a failure past the limit requests a rescan
	// and clears it as well.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count_q <= '0;
		end else if (advance && emit) begin
			if (crc_match || over_limit) begin
				fail_count_q <= '0;
			end else begin
				fail_count_q <= fail_inc[3:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_item_q.temperature_raw <= crc_match ? decoded_temp : 16'h0000;
			result_item_q.crc_ok          <= crc_match;
			result_item_q.rescan_request  <= !crc_match && over_limit;
			result_item_q.result_device   <= item_s1.device_index;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_item_q;

	`TDEC_ASSERT_NOW(a_ok_no_rescan, result_valid_q && result_item_q.crc_ok,
		!result_item_q.rescan_request, "rescan requested on a good CRC")
	`TDEC_ASSERT_NOW(a_bad_crc_zero_temp, result_valid_q && !result_item_q.crc_ok,
		result_item_q.temperature_raw == 16'h0000, "temperature not zero on CRC failure")
	`TDEC_ASSERT_NOW(a_no_result_off_crc_byte, valid_s1 && !is_crc_byte,
		!emit, "result raised for a byte other than the CRC byte")
	`TDEC_ASSERT_NEXT(a_rescan_clears_count, advance && emit && !crc_match && over_limit,
		fail_count_q == 4'd0 && result_item_q.rescan_request,
		"rescan did not clear the failure count")
	`TDEC_ASSERT_NEXT(a_match_clears_count, advance && emit && crc_match,
		fail_count_q == 4'd0, "good CRC did not clear the failure count")

endmodule

`default_nettype wire

// ===== src/tdec_crc8.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One byte of the reflected CRC-8 (x^8+x^5+x^4+1), fully unrolled.
module tdec_crc8 import tdec_pkg::*; (
	input  wire logic [7:0] crc_in,
	input  wire logic [7:0] data,
	output logic      [7:0] crc_out
);

	always_comb begin
		logic [7:0] c;
		c = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

// ===== src/tdec_temp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Converts the kept scratchpad bytes into a 16-bit reading in 1/16 degree units.
module tdec_temp import tdec_pkg::*; (
	input  wire kept_bytes_t       kept,
	input  wire logic      [7:0]   family_code,
	output logic           [15:0]  temperature_raw
);

	logic [15:0] raw;
	logic [15:0] raw_old;
	logic [7:0]  res_bits;

	assign raw      = {kept.temp_msb, kept.temp_lsb};
	assign raw_old  = {raw[12:0], 3'b000};
	assign res_bits = kept.config_reg & RES_MASK;

	always_comb begin
		temperature_raw = raw;
		if (family_code == FAMILY_OLD) begin
			if (kept.count_per_c == COUNT_PER_C) begin
				temperature_raw = (raw_old & OLD_FRAC_MASK) + OLD_FRAC_BIAS
					- {8'h00, kept.count_remain};
			end else begin
				temperature_raw = raw_old;
			end
		end else begin
			case (res_bits)
				RES_9BIT:  temperature_raw = raw & MASK_9BIT;
				RES_10BIT: temperature_raw = raw & MASK_10BIT;
				RES_11BIT: temperature_raw = raw & MASK_11BIT;
				default:   temperature_raw = raw;
			endcase
		end
	end

endmodule

`default_nettype wire
